// File: rtl/core/assert_macros.svh
// assertion macros shared by the allocator rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression holds at every clock edge out of reset
`define SCA_ASSERT_ALWAYS(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
	else $error("assertion failed");

// antecedent in one cycle implies consequent in the next
`define SCA_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("assertion failed");

// antecedent implies consequent in the same cycle
`define SCA_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("assertion failed");

`endif

// File: rtl/core/sca_pkg.sv
// shared types and constants of the slab chunk allocator
`default_nettype none
package sca_pkg;
	localparam int ADDR_W = 18;
	localparam int SIZE_W = 12;
	localparam int STAT_W = 2;

	localparam int PAGE_SIZE_DEF    = 4096;
	localparam int NUM_PAGES_DEF    = 64;
	localparam int NUM_CLASSES_DEF  = 32;
	localparam int GRAIN_SHIFT_DEF  = 3;
	localparam int HEADER_BYTES_DEF = 32;

	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
	localparam logic [STAT_W-1:0] ST_NO_PAGE  = 2'd1;
	localparam logic [STAT_W-1:0] ST_BAD_SIZE = 2'd2;

	typedef struct packed {
		logic              cmd;
		logic [SIZE_W-1:0] req_size;
		logic [ADDR_W-1:0] chunk_addr;
	} req_t;

	typedef struct packed {
		logic [ADDR_W-1:0] result_addr;
		logic [STAT_W-1:0] status;
	} rsp_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;
endpackage
`default_nettype wire

// File: rtl/core/slab_chunk_allocator.sv
// slab chunk allocator top level: request sequencer over page, link and pool memories
// usage:
//   req channel (req_valid / req_ready / req) carries one allocate or free request;
//   rsp channel (rsp_valid / rsp_ready / rsp) returns exactly one response per request
//   requests are worked one at a time; req_ready is high only while the sequencer idles
//   each step is a read of a synchronous memory and a write back; steps per request:
//     bad size: decode only; free outside the pool: decode and page check;
//     allocate with the pool empty: class head check; allocate from a page with room:
//     page read and write, with a link read when the chunk comes off the free list;
//     allocate that takes a new page: one read-modify-write for an empty ring, else a
//     read and three read-modify-write passes for the ring insert; free: one serial
//     divide of the page offset by the chunk size, then a page read; an uncarved chunk
//     is ignored, else the page is written, an empty page goes back to the pool and
//     a full page moves to the ring head
//   after each response the sequencer idles before the next request is taken
//   the response sits in an output register; the next request is taken while it waits,
//   and a later response only holds in the sequencer until the register drains
//   reset: all class rings empty, page pool full (page NUM_PAGES-1 handed out first);
//   no clearing pass runs, the block takes requests straight out of reset
//   page and link memories hold no reset value, the pool stack uses a low-water mark
`default_nettype none
module slab_chunk_allocator #(
	parameter int PAGE_SIZE    = sca_pkg::PAGE_SIZE_DEF,
	parameter int NUM_PAGES    = sca_pkg::NUM_PAGES_DEF,
	parameter int NUM_CLASSES  = sca_pkg::NUM_CLASSES_DEF,
	parameter int GRAIN_SHIFT  = sca_pkg::GRAIN_SHIFT_DEF,
	parameter int HEADER_BYTES = sca_pkg::HEADER_BYTES_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_ready,
	input  sca_pkg::req_t      req,
	output logic               rsp_valid,
	input  wire logic          rsp_ready,
	output sca_pkg::rsp_t      rsp
);
	`include "assert_macros.svh"

	localparam int AW     = sca_pkg::ADDR_W;
	localparam int SW     = sca_pkg::SIZE_W;
	localparam int PW     = $clog2(NUM_PAGES);
	localparam int CLW    = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
	localparam int MAXC   = (PAGE_SIZE - HEADER_BYTES) >> GRAIN_SHIFT;
	localparam int KW     = $clog2(MAXC + 1);
	localparam int CBW    = $clog2((NUM_CLASSES << GRAIN_SHIFT) + 1);
	localparam int BW     = $clog2(NUM_PAGES * PAGE_SIZE);
	localparam int LDEPTH = (NUM_PAGES * PAGE_SIZE) >> GRAIN_SHIFT;
	localparam int LW     = $clog2(LDEPTH);
	localparam int GMASK  = (1 << GRAIN_SHIFT) - 1;
	localparam int PGSH   = $clog2(PAGE_SIZE);

	typedef struct packed {
		logic [PW-1:0] prev;
		logic [PW-1:0] next;
		logic [KW-1:0] used;
		logic [KW-1:0] fh;     // free-list head, chunk index plus one
		logic [KW-1:0] carve;
	} page_t;

	typedef struct packed {
		logic          init;
		logic          sp;
		logic [PW-1:0] pv;
		logic          sn;
		logic [PW-1:0] nv;
	} rmw_t;

	typedef enum logic [4:0] {
		S_IDLE, S_DEC, S_RD, S_RMW_RD, S_RMW_WR,
		S_A_HEAD, S_A_CHK, S_A_NEW, S_A_TAKE,
		S_INS0, S_INS1, S_INS2, S_INS3, S_INS_END,
		S_P_RD, S_P_CHK, S_P_LRD, S_P_LDAT, S_P_WR,
		S_F_DIV0, S_F_DIV1, S_F_CHK, S_F_WR, S_RM2, S_RM3,
		S_DONE
	} state_t;

	// chunks per page for each class
	logic [KW-1:0] cap_tab [NUM_CLASSES];
	for (genvar K = 0; K < NUM_CLASSES; K++) begin : g_cap
		localparam int Cb  = (K + 1) << GRAIN_SHIFT;
		localparam int Cap = (PAGE_SIZE - HEADER_BYTES) / Cb;
		assign cap_tab[K] = KW'(Cap);
	end

	state_t          state_q, ret_q;
	sca_pkg::req_t   req_q;
	sca_pkg::rsp_t   res_q, rsp_q;
	logic            rsp_valid_q;
	logic [CLW-1:0]  cls_q;
	logic [PW-1:0]   pa_q, p_q, t_q, h_q;
	logic [KW-1:0]   c_q, nfh_q, ncarve_q;
	logic [AW-1:0]   cf_q;
	logic            wf_q;
	page_t           e_q;
	rmw_t            rmw_q;
	logic [PW:0]     pool_count_q, low_q;
	logic [PW-1:0]   head_q [NUM_CLASSES];
	logic            hv_q   [NUM_CLASSES];

	// page memory
	page_t           page_mem [NUM_PAGES];
	page_t           pg_rd, pg_wd;
	logic            pg_we;
	logic [PW-1:0]   pg_wa;

	// chunk link memory
	logic [KW-1:0]   link_mem [LDEPTH];
	logic [KW-1:0]   lk_rd;
	logic            lk_we;
	logic [LW-1:0]   lk_a;

	// page pool stack, entries at or above the low mark have been written
	logic [PW-1:0]   pool_mem [NUM_PAGES];
	logic [PW-1:0]   pool_rd_q, pool_ix_q;
	logic            pool_hit_q;
	logic [PW-1:0]   pool_ra;
	logic            pool_we;
	logic [PW-1:0]   pool_val;

	// size decode
	logic [SW:0]     grains;
	logic [CLW-1:0]  cls_w;
	logic            bad_size;
	logic [KW-1:0]   cap;
	logic [CBW-1:0]  cb;
	logic [BW-1:0]   baddr;

	// divider, page number comes straight from the upper address bits
	logic [AW-1:0]   pn;
	logic            div_start;
	logic [AW-1:0]   div_dvd, div_dvs, div_quot;
	sca_pkg::div_stat_t div_stat;

	page_t           rmw_d;
	logic [KW-1:0]   used_dec;
	logic            pg_full_rd;

	assign grains   = ({1'b0, req_q.req_size} + (SW+1)'(GMASK)) >> GRAIN_SHIFT;
	assign cls_w    = CLW'(grains - (SW+1)'(1));
	assign bad_size = (req_q.req_size == '0) || (grains > (SW+1)'(NUM_CLASSES))
		|| (cap_tab[cls_w] == '0);
	assign cap      = cap_tab[cls_q];
	assign cb       = (CBW'(cls_q) + CBW'(1)) << GRAIN_SHIFT;
	assign baddr    = BW'(p_q) * BW'(PAGE_SIZE) + BW'(c_q) * BW'(cb);
	assign lk_a     = LW'(baddr >> GRAIN_SHIFT);
	assign pool_ra  = PW'(pool_count_q - (PW+1)'(1));
	assign pool_val = pool_hit_q ? pool_rd_q : pool_ix_q;
	assign pg_full_rd = (pg_rd.fh == '0) && (pg_rd.carve >= cap);
	assign used_dec = (e_q.used != '0) ? e_q.used - KW'(1) : '0;

	always_comb begin
		rmw_d = pg_rd;
		if (rmw_q.init) begin
			rmw_d.used  = '0;
			rmw_d.fh    = '0;
			rmw_d.carve = '0;
		end
		if (rmw_q.sp) rmw_d.prev = rmw_q.pv;
		if (rmw_q.sn) rmw_d.next = rmw_q.nv;
	end

	// memory write controls
	always_comb begin
		pg_we   = 1'b0;
		pg_wa   = pa_q;
		pg_wd   = rmw_d;
		lk_we   = 1'b0;
		pool_we = 1'b0;
		unique case (state_q)
			S_RMW_WR: begin
				pg_we = 1'b1;
			end
			S_P_WR: begin
				pg_we = 1'b1;
				pg_wa = p_q;
				pg_wd = '{prev: e_q.prev, next: e_q.next, used: e_q.used + KW'(1),
					fh: nfh_q, carve: ncarve_q};
			end
			S_F_WR: begin
				pg_we = 1'b1;
				pg_wa = p_q;
				pg_wd = '{prev: e_q.prev, next: e_q.next, used: used_dec,
					fh: c_q + KW'(1), carve: e_q.carve};
				lk_we = 1'b1;
			end
			S_RM3: begin
				pool_we = !wf_q && (pool_count_q < (PW+1)'(NUM_PAGES));
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (pg_we) page_mem[pg_wa] <= pg_wd;
		pg_rd <= page_mem[pa_q];
	end

	always_ff @(posedge clk) begin
		if (lk_we) link_mem[lk_a] <= e_q.fh;
		lk_rd <= link_mem[lk_a];
	end

	always_ff @(posedge clk) begin
		if (pool_we) pool_mem[PW'(pool_count_q)] <= p_q;
		pool_rd_q  <= pool_mem[pool_ra];
		pool_ix_q  <= pool_ra;
		pool_hit_q <= ({1'b0, pool_ra} >= low_q);
	end

	// page number by shift, chunk index by dividing the page offset
	assign pn        = req_q.chunk_addr >> PGSH;
	assign div_start = (state_q == S_F_DIV0) && (pn < AW'(NUM_PAGES));
	assign div_dvd   = req_q.chunk_addr & AW'(PAGE_SIZE - 1);
	assign div_dvs   = AW'(cb);

	sca_div #(.W(AW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.stat     (div_stat),
		.quot     (div_quot)
	);

	// request sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			ret_q        <= S_IDLE;
			rsp_valid_q  <= 1'b0;
			pool_count_q <= (PW+1)'(NUM_PAGES);
			low_q        <= (PW+1)'(NUM_PAGES);
			for (int i = 0; i < NUM_CLASSES; i++) hv_q[i] <= 1'b0;
		end else begin
			// output register drains unless a new response loads it
			if (rsp_valid_q && rsp_ready && (state_q != S_DONE)) rsp_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						req_q   <= req;
						state_q <= S_DEC;
					end
				end
				S_DEC: begin
					cls_q <= cls_w;
					if (bad_size) begin
						res_q   <= '{result_addr: '0, status: sca_pkg::ST_BAD_SIZE};
						state_q <= S_DONE;
					end else begin
						res_q <= '{result_addr: '0, status: sca_pkg::ST_OK};
						if (req_q.cmd == sca_pkg::CMD_ALLOC)
							state_q <= S_A_HEAD;
						else
							state_q <= S_F_DIV0;
					end
				end
				S_RD: state_q <= ret_q;
				S_RMW_RD: state_q <= S_RMW_WR;
				S_RMW_WR: state_q <= ret_q;
				S_A_HEAD: begin
					if (hv_q[cls_q]) begin
						pa_q    <= head_q[cls_q];
						ret_q   <= S_A_CHK;
						state_q <= S_RD;
					end else begin
						state_q <= S_A_NEW;
					end
				end
				S_A_CHK: begin
					if (!pg_full_rd) begin
						p_q     <= pa_q;
						state_q <= S_P_RD;
					end else begin
						state_q <= S_A_NEW;
					end
				end
				S_A_NEW: begin
					if (pool_count_q == '0) begin
						res_q.status <= sca_pkg::ST_NO_PAGE;
						state_q      <= S_DONE;
					end else begin
						state_q <= S_A_TAKE;
					end
				end
				S_A_TAKE: begin
					p_q          <= pool_val;
					pool_count_q <= pool_count_q - (PW+1)'(1);
					if ((pool_count_q - (PW+1)'(1)) < low_q)
						low_q <= pool_count_q - (PW+1)'(1);
					state_q <= S_INS0;
				end
				// ring insert of page p_q at the head of the class ring
				S_INS0: begin
					h_q <= head_q[cls_q];
					if (!hv_q[cls_q]) begin
						pa_q    <= p_q;
						rmw_q   <= '{init: (req_q.cmd == sca_pkg::CMD_ALLOC), sp: 1'b1,
							pv: p_q, sn: 1'b1, nv: p_q};
						ret_q   <= S_INS_END;
						state_q <= S_RMW_RD;
					end else begin
						pa_q    <= head_q[cls_q];
						ret_q   <= S_INS1;
						state_q <= S_RD;
					end
				end
				S_INS1: begin
					t_q     <= pg_rd.prev;
					pa_q    <= p_q;
					rmw_q   <= '{init: (req_q.cmd == sca_pkg::CMD_ALLOC), sp: 1'b1,
						pv: pg_rd.prev, sn: 1'b1, nv: h_q};
					ret_q   <= S_INS2;
					state_q <= S_RMW_RD;
				end
				S_INS2: begin
					pa_q    <= t_q;
					rmw_q   <= '{init: 1'b0, sp: 1'b0, pv: p_q, sn: 1'b1, nv: p_q};
					ret_q   <= S_INS3;
					state_q <= S_RMW_RD;
				end
				S_INS3: begin
					pa_q    <= h_q;
					rmw_q   <= '{init: 1'b0, sp: 1'b1, pv: p_q, sn: 1'b0, nv: p_q};
					ret_q   <= S_INS_END;
					state_q <= S_RMW_RD;
				end
				S_INS_END: begin
					head_q[cls_q] <= p_q;
					hv_q[cls_q]   <= 1'b1;
					state_q <= (req_q.cmd == sca_pkg::CMD_ALLOC) ? S_P_RD : S_DONE;
				end
				// chunk pop from page p_q
				S_P_RD: begin
					pa_q    <= p_q;
					ret_q   <= S_P_CHK;
					state_q <= S_RD;
				end
				S_P_CHK: begin
					e_q <= pg_rd;
					if (pg_rd.fh != '0) begin
						c_q     <= pg_rd.fh - KW'(1);
						state_q <= S_P_LRD;
					end else begin
						c_q      <= pg_rd.carve;
						nfh_q    <= '0;
						ncarve_q <= pg_rd.carve + KW'(1);
						state_q  <= S_P_WR;
					end
				end
				S_P_LRD: state_q <= S_P_LDAT;
				S_P_LDAT: begin
					nfh_q    <= lk_rd;
					ncarve_q <= e_q.carve;
					state_q  <= S_P_WR;
				end
				S_P_WR: begin
					// page now full: head moves on, page stays in the ring
					if ((nfh_q == '0) && (ncarve_q >= cap))
						head_q[cls_q] <= e_q.next;
					res_q.result_addr <= AW'(baddr);
					state_q <= S_DONE;
				end
				// free path: page outside the pool is ignored, else divide the offset
				S_F_DIV0: begin
					if (pn >= AW'(NUM_PAGES)) begin
						state_q <= S_DONE;
					end else begin
						p_q     <= PW'(pn);
						state_q <= S_F_DIV1;
					end
				end
				S_F_DIV1: begin
					if (div_stat.done) begin
						cf_q    <= div_quot;
						pa_q    <= p_q;
						ret_q   <= S_F_CHK;
						state_q <= S_RD;
					end
				end
				S_F_CHK: begin
					e_q  <= pg_rd;
					wf_q <= pg_full_rd;
					c_q  <= KW'(cf_q);
					// uncarved chunk or header area: ignored
					if ((cf_q >= AW'(pg_rd.carve)) || (cf_q >= AW'(cap)))
						state_q <= S_DONE;
					else
						state_q <= S_F_WR;
				end
				S_F_WR: begin
					if (wf_q || (used_dec == '0)) begin
						pa_q    <= e_q.prev;
						rmw_q   <= '{init: 1'b0, sp: 1'b0, pv: e_q.prev, sn: 1'b1,
							nv: e_q.next};
						ret_q   <= S_RM2;
						state_q <= S_RMW_RD;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_RM2: begin
					pa_q    <= e_q.next;
					rmw_q   <= '{init: 1'b0, sp: 1'b1, pv: e_q.prev, sn: 1'b0,
						nv: e_q.next};
					ret_q   <= S_RM3;
					state_q <= S_RMW_RD;
				end
				S_RM3: begin
					if (hv_q[cls_q] && (head_q[cls_q] == p_q)) begin
						if (e_q.next == p_q) hv_q[cls_q] <= 1'b0;
						else head_q[cls_q] <= e_q.next;
					end
					if (wf_q) begin
						state_q <= S_INS0;
					end else begin
						if (pool_count_q < (PW+1)'(NUM_PAGES))
							pool_count_q <= pool_count_q + (PW+1)'(1);
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (!rsp_valid_q || rsp_ready) begin
						rsp_q       <= res_q;
						rsp_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	`SCA_ASSERT_ALWAYS(a_pool_bound, pool_count_q <= (PW+1)'(NUM_PAGES))
	`SCA_ASSERT_ALWAYS(a_low_mark, low_q <= pool_count_q)
	`SCA_ASSERT_NEXT(a_one_request, req_valid && req_ready, !req_ready)
	`SCA_ASSERT_IMPL(a_err_zero, rsp_valid && (rsp.status != sca_pkg::ST_OK), rsp.result_addr == '0)
endmodule
`default_nettype wire

// File: rtl/core/sca_div.sv
// iterative restoring divider, one quotient bit per cycle
`default_nettype none
module sca_div #(
	parameter int W = sca_pkg::ADDR_W
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         start,
	input  wire logic [W-1:0] dividend,
	input  wire logic [W-1:0] divisor,
	output sca_pkg::div_stat_t stat,
	output logic      [W-1:0] quot
);
	localparam int CNT_W = $clog2(W + 1);

	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [W-1:0]     quot_q;
	logic [W-1:0]     rem_q;
	logic [W-1:0]     dvs_q;
	logic [W+1:0]     shifted;
	logic [W+1:0]     diff;

	assign shifted = {1'b0, rem_q, quot_q[W-1]};
	assign diff    = shifted - (W+2)'(dvs_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quot_q <= dividend;
			rem_q  <= '0;
			dvs_q  <= divisor;
		end else if (busy_q) begin
			if (!diff[W+1]) begin
				rem_q  <= diff[W-1:0];
				quot_q <= {quot_q[W-2:0], 1'b1};
			end else begin
				rem_q  <= shifted[W-1:0];
				quot_q <= {quot_q[W-2:0], 1'b0};
			end
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quot      = quot_q;
endmodule
`default_nettype wire

// File: tb/tb.sv
// testbench for the slab chunk allocator: directed and random requests checked against a predictor
`timescale 1ns / 1ps
`default_nettype none

module tb;
	localparam int PAGE_BYTES   = sca_pkg::PAGE_SIZE_DEF;
	localparam int PAGE_COUNT   = sca_pkg::NUM_PAGES_DEF;
	localparam int CLASS_COUNT  = sca_pkg::NUM_CLASSES_DEF;
	localparam int GRAIN        = sca_pkg::GRAIN_SHIFT_DEF;
	localparam int HDR_BYTES    = sca_pkg::HEADER_BYTES_DEF;
	localparam int LINK_ENTRIES = (PAGE_COUNT * PAGE_BYTES) >> GRAIN;
	localparam int CYCLE_LIMIT  = 1500000;

	// predictor of the allocator plus the queue of responses it still owes
	class slab_scoreboard;
		bit head_valid[CLASS_COUNT];
		int class_head[CLASS_COUNT];
		int page_prev[PAGE_COUNT];
		int page_next[PAGE_COUNT];
		int page_used[PAGE_COUNT];
		int page_free_head[PAGE_COUNT];
		int page_carve_mark[PAGE_COUNT];
		int chunk_link[LINK_ENTRIES];
		int pool_stack[PAGE_COUNT];
		int pool_count;
		sca_pkg::rsp_t owed[$];
		int errors;

		function new();
			for (int i = 0; i < PAGE_COUNT; i++)
				pool_stack[i] = i;
			pool_count = PAGE_COUNT;
			errors = 0;
		endfunction

		function int chunk_bytes(int cls);
			return (cls + 1) << GRAIN;
		endfunction

		function int capacity(int cls);
			return (PAGE_BYTES - HDR_BYTES) / chunk_bytes(cls);
		endfunction

		function bit size_class(int size, output int cls);
			int grains;
			grains = (size + (1 << GRAIN) - 1) >> GRAIN;
			cls = grains - 1;
			return size != 0 && grains <= CLASS_COUNT && capacity(grains - 1) != 0;
		endfunction

		function bit page_full(int p, int cls);
			return page_free_head[p] == 0 && page_carve_mark[p] >= capacity(cls);
		endfunction

		function void ring_insert(int cls, int p);
			int h, t;
			if (!head_valid[cls]) begin
				page_next[p] = p;
				page_prev[p] = p;
			end else begin
				h = class_head[cls];
				t = page_prev[h];
				page_prev[p] = t;
				page_next[t] = p;
				page_next[p] = h;
				page_prev[h] = p;
			end
			class_head[cls] = p;
			head_valid[cls] = 1;
		endfunction

		function void ring_remove(int cls, int p);
			int n, v;
			n = page_next[p];
			v = page_prev[p];
			page_next[v] = n;
			page_prev[n] = v;
			if (head_valid[cls] && class_head[cls] == p) begin
				if (n == p)
					head_valid[cls] = 0;
				else
					class_head[cls] = n;
			end
		endfunction

		// apply one accepted request and queue the response it must produce
		function sca_pkg::rsp_t note_request(sca_pkg::req_t r);
			sca_pkg::rsp_t e;
			int cls, p, c, cb, idx, offs;
			bit was_full;
			e = '0;
			if (!size_class(int'(r.req_size), cls)) begin
				e.status = sca_pkg::ST_BAD_SIZE;
			end else if (r.cmd == sca_pkg::CMD_ALLOC) begin
				cb = chunk_bytes(cls);
				if ((!head_valid[cls] || page_full(class_head[cls], cls)) && pool_count == 0) begin
					e.status = sca_pkg::ST_NO_PAGE;
				end else begin
					if (!head_valid[cls] || page_full(class_head[cls], cls)) begin
						pool_count--;
						p = pool_stack[pool_count];
						page_used[p] = 0;
						page_free_head[p] = 0;
						page_carve_mark[p] = 0;
						ring_insert(cls, p);
					end
					p = class_head[cls];
					if (page_free_head[p] != 0) begin
						c = page_free_head[p] - 1;
						page_free_head[p] = chunk_link[(p * PAGE_BYTES + c * cb) >> GRAIN];
					end else begin
						c = page_carve_mark[p];
						page_carve_mark[p] = c + 1;
					end
					page_used[p]++;
					if (page_full(p, cls))
						class_head[cls] = page_next[p];
					e.result_addr = sca_pkg::ADDR_W'(p * PAGE_BYTES + c * cb);
				end
			end else begin
				cb = chunk_bytes(cls);
				p = int'(r.chunk_addr) / PAGE_BYTES;
				offs = int'(r.chunk_addr) % PAGE_BYTES;
				c = offs / cb;
				// outside the pool and uncarved chunks leave everything alone
				if (p < PAGE_COUNT && c < page_carve_mark[p] && c < capacity(cls)) begin
					was_full = page_full(p, cls);
					idx = (p * PAGE_BYTES + c * cb) >> GRAIN;
					chunk_link[idx] = page_free_head[p];
					page_free_head[p] = c + 1;
					if (page_used[p] != 0)
						page_used[p]--;
					if (was_full || page_used[p] == 0) begin
						ring_remove(cls, p);
						if (was_full) begin
							ring_insert(cls, p);
						end else if (pool_count < PAGE_COUNT) begin
							pool_stack[pool_count] = p;
							pool_count++;
						end
					end
				end
			end
			owed.push_back(e);
			return e;
		endfunction

		function void flag(string msg);
			errors++;
			if (errors <= 10)
				$display("mismatch: %s", msg);
		endfunction

		function void check_response(sca_pkg::rsp_t a);
			sca_pkg::rsp_t e;
			if (owed.size() == 0) begin
				flag($sformatf("response addr=%h status=%0d with none expected",
					a.result_addr, a.status));
			end else begin
				e = owed.pop_front();
				if (a.result_addr !== e.result_addr)
					flag($sformatf("result_addr expected %h actual %h",
						e.result_addr, a.result_addr));
				if (a.status !== e.status)
					flag($sformatf("status expected %0d actual %0d", e.status, a.status));
			end
		endfunction
	endclass

	typedef struct {
		logic [sca_pkg::ADDR_W-1:0] addr;
		int cls;
	} held_chunk_t;

	logic           clk;
	logic           arst_n;
	logic           req_valid;
	logic           req_ready;
	sca_pkg::req_t  req;
	logic           rsp_valid;
	logic           rsp_ready;
	sca_pkg::rsp_t  rsp;

	slab_chunk_allocator DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	slab_scoreboard sb = new();
	held_chunk_t held[$];
	int tx_idle_pct;
	int rx_idle_pct;
	int cycles;
	sca_pkg::rsp_t last_rsp;

	// free-running clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// watchdog against a stuck handshake
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// receiver back-pressure at the current idle rate
	always @(posedge clk) begin
		if (!arst_n)
			rsp_ready <= 1'b0;
		else
			rsp_ready <= ($urandom_range(99) >= rx_idle_pct);
	end

	// response monitor, sampling pre-edge values
	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready)
			sb.check_response(rsp);
	end

	// present one request, wait for the handshake, then update the predictor
	task automatic send_request(input logic cmd, input int size, input int addr);
		sca_pkg::req_t r;
		if ($urandom_range(99) < tx_idle_pct) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		r.cmd = cmd;
		r.req_size = sca_pkg::SIZE_W'(size);
		r.chunk_addr = sca_pkg::ADDR_W'(addr);
		req <= r;
		req_valid <= 1'b1;
		forever begin
			@(posedge clk);
			if (req_ready)
				break;
		end
		last_rsp = sb.note_request(r);
		if (cmd == sca_pkg::CMD_ALLOC && last_rsp.status == sca_pkg::ST_OK)
			held.push_back('{addr: last_rsp.result_addr, cls: (size + 7) / 8 - 1});
	endtask

	// random size inside one class
	function automatic int size_of_class(int cls);
		return $urandom_range(cls * 8 + 8, cls * 8 + 1);
	endfunction

	// free a held chunk, possibly misaligned, with any size of its class
	task automatic free_held(input int k);
		held_chunk_t h;
		h = held[k];
		held.delete(k);
		send_request(sca_pkg::CMD_FREE, size_of_class(h.cls),
			int'(h.addr) + $urandom_range(sb.chunk_bytes(h.cls) - 1));
	endtask

	// free an index at or past the carve mark of a live page, header area included
	task automatic free_uncarved();
		held_chunk_t h;
		int p, cb, capc, c, offs;
		h = held[$urandom_range(held.size() - 1)];
		p = int'(h.addr) / PAGE_BYTES;
		cb = sb.chunk_bytes(h.cls);
		capc = sb.capacity(h.cls);
		c = $urandom_range(capc, sb.page_carve_mark[p]);
		if (c == capc)
			offs = $urandom_range(PAGE_BYTES - 1, capc * cb);
		else
			offs = c * cb + $urandom_range(cb - 1);
		send_request(sca_pkg::CMD_FREE, size_of_class(h.cls), p * PAGE_BYTES + offs);
	endtask

	task automatic random_request();
		int roll, sz;
		roll = $urandom_range(99);
		if (roll < 45 || held.size() == 0) begin
			if ($urandom_range(99) < 6)
				sz = ($urandom_range(1)) ? 0 : $urandom_range(4095, 257);
			else if ($urandom_range(1))
				sz = $urandom_range(64, 1);
			else
				sz = $urandom_range(256, 1);
			send_request(sca_pkg::CMD_ALLOC, sz, $urandom_range(262143));
		end else if (roll < 88) begin
			free_held($urandom_range(held.size() - 1));
		end else if (roll < 94) begin
			free_uncarved();
		end else begin
			// free with a bad size changes nothing
			sz = ($urandom_range(1)) ? 0 : $urandom_range(4095, 257);
			send_request(sca_pkg::CMD_FREE, sz, $urandom_range(262143));
		end
	endtask

	initial begin
		int guard;
		cycles = 0;
		tx_idle_pct = 14;
		rx_idle_pct = 72;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		rsp_ready = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: bad sizes on both commands
		send_request(sca_pkg::CMD_ALLOC, 0, 0);
		send_request(sca_pkg::CMD_ALLOC, 4095, 262143);
		send_request(sca_pkg::CMD_ALLOC, 257, 0);
		send_request(sca_pkg::CMD_FREE, 0, 262143);
		send_request(sca_pkg::CMD_FREE, 300, 4096);
		// directed: class extremes and rounding edges
		send_request(sca_pkg::CMD_ALLOC, 1, 0);
		send_request(sca_pkg::CMD_ALLOC, 8, 0);
		send_request(sca_pkg::CMD_ALLOC, 9, 0);
		send_request(sca_pkg::CMD_ALLOC, 256, 0);
		send_request(sca_pkg::CMD_ALLOC, 255, 0);
		send_request(sca_pkg::CMD_ALLOC, 249, 0);
		// misaligned free, reuse of the freed chunk, free emptying a page
		free_held(0);
		send_request(sca_pkg::CMD_ALLOC, 3, 0);
		free_uncarved();
		free_held(held.size() - 1);
		free_held(held.size() - 1);
		while (held.size() != 0)
			free_held(0);
		send_request(sca_pkg::CMD_ALLOC, 128, 0);
		free_uncarved();

		// one chunk in every class, a page for each class that has none, then the largest
		// class keeps taking pages until the pool runs dry
		for (int k = 0; k < CLASS_COUNT; k++)
			send_request(sca_pkg::CMD_ALLOC, size_of_class(k), 0);
		guard = 0;
		do begin
			send_request(sca_pkg::CMD_ALLOC, size_of_class(CLASS_COUNT - 1), 0);
			guard++;
		end while (last_rsp.status != sca_pkg::ST_NO_PAGE && guard < 600);
		send_request(sca_pkg::CMD_ALLOC, size_of_class(CLASS_COUNT - 1), 0);
		send_request(sca_pkg::CMD_ALLOC, $urandom_range(256, 1), 0);

		// random traffic under three idling profiles, frees return pages to the pool
		for (int i = 0; i < 50; i++)
			random_request();
		tx_idle_pct = 72;
		rx_idle_pct = 14;
		for (int i = 0; i < 50; i++)
			random_request();
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		for (int i = 0; i < 50; i++)
			random_request();
		req_valid <= 1'b0;

		while (sb.owed.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		if (sb.errors == 0 && sb.owed.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule

`default_nettype wire
